FILE: hw/rtl/mf3_pkg.sv
// shared constants, types and register codes for the 3x3 median filter
`default_nettype none

package mf3_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int MAX_WIDTH      = 1024;
    localparam int COL_BITS       = $clog2(MAX_WIDTH);
    localparam int WIDTH_BITS     = COL_BITS + 1;
    localparam int HEIGHT_BITS    = 12;
    localparam int ROW_BITS       = HEIGHT_BITS + 1;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = HEIGHT_BITS;
    localparam int WIN_SIZE       = 9;
    localparam int FIFO_DEPTH     = 8;
    localparam int FIFO_PTR_BITS  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS  = FIFO_PTR_BITS + 1;
    localparam int RESET_WIDTH    = 64;
    localparam int RESET_HEIGHT   = 64;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef sample_t [WIN_SIZE-1:0] window_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1
    } cfg_reg_t;

    // per-word control that travels beside the window
    typedef struct packed {
        logic has_result;
        logic frame_end;
        logic top_out;
        logic bot_out;
        logic left_out;
        logic right_out;
    } ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/mf3_ifs.sv
// stream and configuration channel interfaces of the median filter
`default_nettype none

interface mf3_pix_if;
    logic             valid;
    logic             ready;
    mf3_pkg::sample_t sample;
    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface mf3_med_if;
    logic             valid;
    logic             ready;
    mf3_pkg::sample_t median;
    logic             frame_end;
    modport source (output valid, output median, output frame_end, input ready);
    modport sink (input valid, input median, input frame_end, output ready);
endinterface

interface mf3_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [mf3_pkg::CFG_INDEX_BITS-1:0]   index;
    logic [mf3_pkg::CFG_DATA_BITS-1:0]    data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/mf3_ram.sv
// generic single-clock ram, one write port and one registered read port
`default_nettype none

module mf3_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/mf3_window.sv
// two-row line ram with read-modify-write, clearing pass and 3x3 window registers
`default_nettype none

module mf3_window (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         accept,
    input  wire mf3_pkg::sample_t             acc_sample,
    input  wire logic [mf3_pkg::COL_BITS-1:0] acc_col,
    input  wire mf3_pkg::ctrl_t               acc_ctrl,
    output logic                              clearing,
    output logic                              win_valid,
    output mf3_pkg::ctrl_t                    win_ctrl,
    output mf3_pkg::window_t                  win_vals
);

    localparam int LINE_BITS = 2 * mf3_pkg::SAMPLE_BITS;

    // clearing pass state
    logic                         clr_reg;
    logic [mf3_pkg::COL_BITS-1:0] clr_cnt_reg;

    // stage a: ram read in flight
    logic                         a_valid_reg;
    mf3_pkg::sample_t             a_sample_reg;
    logic [mf3_pkg::COL_BITS-1:0] a_col_reg;
    mf3_pkg::ctrl_t               a_ctrl_reg;
    logic                         a_fwd_hit_reg;
    logic [LINE_BITS-1:0]         a_fwd_data_reg;

    // stage b: window
    logic                         b_valid_reg;
    mf3_pkg::ctrl_t               b_ctrl_reg;
    mf3_pkg::window_t             win_reg;

    logic [LINE_BITS-1:0]         rd_data;
    logic [LINE_BITS-1:0]         line_cur;
    mf3_pkg::sample_t             cur_older;
    mf3_pkg::sample_t             cur_newer;
    logic [LINE_BITS-1:0]         item_wr_data;
    logic                         wr_en;
    logic [mf3_pkg::COL_BITS-1:0] wr_addr;
    logic [LINE_BITS-1:0]         wr_data;

    // read-first ram: a read issued on the edge of the previous write misses it
    assign line_cur     = a_fwd_hit_reg ? a_fwd_data_reg : rd_data;
    assign cur_older    = line_cur[LINE_BITS-1:mf3_pkg::SAMPLE_BITS];
    assign cur_newer    = line_cur[mf3_pkg::SAMPLE_BITS-1:0];
    // newer row moves to older, incoming word becomes newer
    assign item_wr_data = {cur_newer, a_sample_reg};

    assign wr_en   = clr_reg | a_valid_reg;
    assign wr_addr = clr_reg ? clr_cnt_reg : a_col_reg;
    assign wr_data = clr_reg ? '0 : item_wr_data;

    mf3_ram #(
        .WIDTH (LINE_BITS),
        .DEPTH (mf3_pkg::MAX_WIDTH)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (accept),
        .rd_addr (acc_col),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg     <= 1'b1;
            clr_cnt_reg <= '0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            win_reg     <= '0;
        end
        else
        begin
            if (clr_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == mf3_pkg::COL_BITS'(mf3_pkg::MAX_WIDTH - 1))
                begin
                    clr_reg <= 1'b0;
                end
            end
            a_valid_reg <= accept;
            b_valid_reg <= a_valid_reg;
            if (a_valid_reg)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    win_reg[k * 3]     <= win_reg[k * 3 + 1];
                    win_reg[k * 3 + 1] <= win_reg[k * 3 + 2];
                end
                win_reg[2] <= cur_older;
                win_reg[5] <= cur_newer;
                win_reg[8] <= a_sample_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_sample_reg   <= acc_sample;
            a_col_reg      <= acc_col;
            a_ctrl_reg     <= acc_ctrl;
            a_fwd_hit_reg  <= a_valid_reg && (a_col_reg == acc_col);
            a_fwd_data_reg <= item_wr_data;
        end
        if (a_valid_reg)
        begin
            b_ctrl_reg <= a_ctrl_reg;
        end
    end

    // zero the window taps that fall outside the image
    always_comb
    begin
        for (int dr = 0; dr < 3; dr++)
        begin
            for (int dc = 0; dc < 3; dc++)
            begin
                if ((dr == 0 && b_ctrl_reg.top_out) || (dr == 2 && b_ctrl_reg.bot_out) ||
                    (dc == 0 && b_ctrl_reg.left_out) || (dc == 2 && b_ctrl_reg.right_out))
                begin
                    win_vals[dr * 3 + dc] = '0;
                end
                else
                begin
                    win_vals[dr * 3 + dc] = win_reg[dr * 3 + dc];
                end
            end
        end
    end

    assign clearing  = clr_reg;
    assign win_valid = b_valid_reg;
    assign win_ctrl  = b_ctrl_reg;

`ifndef ASSERT_OFF
    a_no_item_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n) clr_reg |-> !a_valid_reg
    ) else $error("line ram item write during clearing pass");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/mf3_median.sv
// pipelined median-of-nine network: row sort, column reduce, final median of three
`default_nettype none

module mf3_median (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 win_valid,
    input  wire mf3_pkg::ctrl_t       win_ctrl,
    input  wire mf3_pkg::window_t     win_vals,
    output logic                      res_valid,
    output mf3_pkg::sample_t          res_median,
    output logic                      res_frame_end
);

    function automatic mf3_pkg::sample_t min2(mf3_pkg::sample_t a, mf3_pkg::sample_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic mf3_pkg::sample_t max2(mf3_pkg::sample_t a, mf3_pkg::sample_t b);
        return (a < b) ? b : a;
    endfunction

    function automatic mf3_pkg::sample_t min3(mf3_pkg::sample_t a, mf3_pkg::sample_t b,
                                              mf3_pkg::sample_t c);
        return min2(min2(a, b), c);
    endfunction

    function automatic mf3_pkg::sample_t max3(mf3_pkg::sample_t a, mf3_pkg::sample_t b,
                                              mf3_pkg::sample_t c);
        return max2(max2(a, b), c);
    endfunction

    function automatic mf3_pkg::sample_t med3(mf3_pkg::sample_t a, mf3_pkg::sample_t b,
                                              mf3_pkg::sample_t c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    // stage c: each row sorted into low, mid, high
    logic             c_valid_reg;
    logic             c_end_reg;
    mf3_pkg::sample_t c_lo_reg [3];
    mf3_pkg::sample_t c_md_reg [3];
    mf3_pkg::sample_t c_hi_reg [3];

    // stage d: max of lows, median of mids, min of highs
    logic             d_valid_reg;
    logic             d_end_reg;
    mf3_pkg::sample_t d_lo_reg;
    mf3_pkg::sample_t d_md_reg;
    mf3_pkg::sample_t d_hi_reg;

    // stage e: result
    logic             e_valid_reg;
    logic             e_end_reg;
    mf3_pkg::sample_t e_med_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else
        begin
            c_valid_reg <= win_valid && win_ctrl.has_result;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        c_end_reg <= win_ctrl.frame_end;
        for (int k = 0; k < 3; k++)
        begin
            c_lo_reg[k] <= min3(win_vals[k * 3], win_vals[k * 3 + 1], win_vals[k * 3 + 2]);
            c_md_reg[k] <= med3(win_vals[k * 3], win_vals[k * 3 + 1], win_vals[k * 3 + 2]);
            c_hi_reg[k] <= max3(win_vals[k * 3], win_vals[k * 3 + 1], win_vals[k * 3 + 2]);
        end
        d_end_reg <= c_end_reg;
        d_lo_reg  <= max3(c_lo_reg[0], c_lo_reg[1], c_lo_reg[2]);
        d_md_reg  <= med3(c_md_reg[0], c_md_reg[1], c_md_reg[2]);
        d_hi_reg  <= min3(c_hi_reg[0], c_hi_reg[1], c_hi_reg[2]);
        e_end_reg <= d_end_reg;
        e_med_reg <= med3(d_lo_reg, d_md_reg, d_hi_reg);
    end

    assign res_valid     = e_valid_reg;
    assign res_median    = e_med_reg;
    assign res_frame_end = e_end_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/mf3_fifo.sv
// small result fifo in flops that drives the output channel
`default_nettype none

module mf3_fifo (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire mf3_pkg::sample_t push_median,
    input  wire logic             push_frame_end,
    mf3_med_if.source             med_out
);

    typedef struct packed {
        mf3_pkg::sample_t median;
        logic             frame_end;
    } entry_t;

    entry_t                            mem_reg [mf3_pkg::FIFO_DEPTH];
    logic [mf3_pkg::FIFO_PTR_BITS-1:0] wr_ptr_reg;
    logic [mf3_pkg::FIFO_PTR_BITS-1:0] rd_ptr_reg;
    logic [mf3_pkg::FIFO_CNT_BITS-1:0] count_reg;
    logic                              pop;
    logic                              full;

    assign pop  = med_out.valid && med_out.ready;
    assign full = (count_reg == mf3_pkg::FIFO_CNT_BITS'(mf3_pkg::FIFO_DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= '{median: push_median, frame_end: push_frame_end};
        end
    end

    assign med_out.valid     = (count_reg != '0);
    assign med_out.median    = mem_reg[rd_ptr_reg].median;
    assign med_out.frame_end = mem_reg[rd_ptr_reg].frame_end;

`ifndef ASSERT_OFF
    a_no_overflow: assert property (
        @(posedge clk) disable iff (!rst_n) !(push && full)
    ) else $error("result fifo overflow");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/median_filter_3x3_zero_pad.sv
// top level of the streaming 3x3 zero-padded median filter
`default_nettype none

// Streaming 3x3 median filter over a raster image. Pixel words enter on pix_in in raster order,
// image_width words per row and image_height rows; positions outside the image count as zero.
// The median for a pixel leaves on med_out once the word one row down and one column right has
// been taken, so after each frame the host sends image_width+1 padding words whose values are
// ignored; the last of them yields the result for the last pixel, marked with frame_end. The
// first image_width+1 words of a frame give no result. The block takes one word per clock while
// pix_in is ready; a result reaches med_out through one line ram read, one window stage, three
// median stages and one fifo write. The two previous rows live in one 1024 x 32 line ram (older
// and newer row side by side), read at the word's column and written back in the next cycle,
// with a bypass when the next word hits the same column (image width 1, or the first word of a
// new frame). After reset the line ram is zeroed, one column per cycle, so pix_in stays not
// ready until all 1024 columns are clear; configuration writes are taken at any time. An
// 8-entry result fifo plus a credit count lets pix_in stay ready while results wait on med_out,
// until all 8 entries are reserved.
// Register 0 is image_width (low 11 bits kept, 0 acts as 1, above 1024 acts as 1024), register 1
// image_height (0 acts as 1); both reset to 64 and should change only between frames.
module median_filter_3x3_zero_pad (
    input  wire logic    clk,
    input  wire logic    rst_n,
    mf3_pix_if.sink      pix_in,
    mf3_med_if.source    med_out,
    mf3_cfg_if.sink      cfg
);

    // configuration
    logic [mf3_pkg::WIDTH_BITS-1:0]    width_reg;
    logic [mf3_pkg::HEIGHT_BITS-1:0]   height_reg;
    logic [mf3_pkg::WIDTH_BITS-1:0]    w_eff;
    logic [mf3_pkg::HEIGHT_BITS-1:0]   h_eff;

    // raster position of the next word
    logic [mf3_pkg::COL_BITS-1:0]      col_reg;
    logic [mf3_pkg::COL_BITS-1:0]      col_next;
    logic [mf3_pkg::ROW_BITS-1:0]      row_reg;
    logic [mf3_pkg::ROW_BITS-1:0]      row_next;

    // results reserved in pipeline plus fifo
    logic [mf3_pkg::FIFO_CNT_BITS-1:0] credit_reg;
    logic [mf3_pkg::FIFO_CNT_BITS-1:0] credit_next;

    logic                              accept;
    logic                              pop;
    logic                              clearing;
    mf3_pkg::sample_t                  acc_sample;
    mf3_pkg::ctrl_t                    acc_ctrl;

    // center position of the window this word completes
    logic [mf3_pkg::ROW_BITS:0]        cr_full;
    logic [mf3_pkg::ROW_BITS-1:0]      cr;
    logic                              cr_neg;
    logic [mf3_pkg::WIDTH_BITS-1:0]    cc;
    logic                              row_end;

    logic                              win_valid;
    mf3_pkg::ctrl_t                    win_ctrl;
    mf3_pkg::window_t                  win_vals;
    logic                              res_valid;
    mf3_pkg::sample_t                  res_median;
    logic                              res_frame_end;

    assign cfg.ready = 1'b1;

    // clamp the sizes
    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = mf3_pkg::WIDTH_BITS'(1);
        end
        else if (width_reg > mf3_pkg::WIDTH_BITS'(mf3_pkg::MAX_WIDTH))
        begin
            w_eff = mf3_pkg::WIDTH_BITS'(mf3_pkg::MAX_WIDTH);
        end
        else
        begin
            w_eff = width_reg;
        end
        h_eff = (height_reg == '0) ? mf3_pkg::HEIGHT_BITS'(1) : height_reg;
    end

    assign accept = pix_in.valid && pix_in.ready;
    assign pop    = med_out.valid && med_out.ready;

    // accept only with the line ram cleared and a fifo slot reserved
    assign pix_in.ready = !clearing && (credit_reg < mf3_pkg::FIFO_CNT_BITS'(mf3_pkg::FIFO_DEPTH));

    // padding rows store zero
    assign acc_sample = (row_reg >= {1'b0, h_eff}) ? '0 : pix_in.sample;

    // column zero closes the row two above, otherwise the row above one column back
    always_comb
    begin
        cr_full = {1'b0, row_reg} - ((col_reg == '0) ? (mf3_pkg::ROW_BITS + 1)'(2)
                                                     : (mf3_pkg::ROW_BITS + 1)'(1));
        cr_neg  = cr_full[mf3_pkg::ROW_BITS];
        cr      = cr_full[mf3_pkg::ROW_BITS-1:0];
        cc      = (col_reg == '0) ? (w_eff - 1'b1) : ({1'b0, col_reg} - 1'b1);

        acc_ctrl.has_result = !cr_neg && (cr < {1'b0, h_eff}) && (cc < w_eff);
        acc_ctrl.frame_end  = (cr == ({1'b0, h_eff} - 1'b1)) && (cc == (w_eff - 1'b1));
        acc_ctrl.top_out    = (cr == '0);
        acc_ctrl.bot_out    = ({1'b0, cr} + 1'b1) >= {2'b00, h_eff};
        acc_ctrl.left_out   = (cc == '0);
        acc_ctrl.right_out  = ({1'b0, cc} + 1'b1) >= {1'b0, w_eff};
    end

    // raster advance; the row after the padding row restarts the frame
    always_comb
    begin
        row_end  = {1'b0, row_reg} >= ({2'b00, h_eff} + 1'b1);
        col_next = col_reg;
        row_next = row_reg;
        if (row_end)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (({1'b0, col_reg} + 1'b1) >= w_eff)
        begin
            col_next = '0;
            row_next = row_reg + 1'b1;
        end
        else
        begin
            col_next = col_reg + 1'b1;
        end
    end

    always_comb
    begin
        credit_next = credit_reg;
        if (accept && acc_ctrl.has_result && !pop)
        begin
            credit_next = credit_reg + 1'b1;
        end
        else if (pop && !(accept && acc_ctrl.has_result))
        begin
            credit_next = credit_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= mf3_pkg::WIDTH_BITS'(mf3_pkg::RESET_WIDTH);
            height_reg <= mf3_pkg::HEIGHT_BITS'(mf3_pkg::RESET_HEIGHT);
            col_reg    <= '0;
            row_reg    <= '0;
            credit_reg <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (mf3_pkg::cfg_reg_t'(cfg.index))
                    mf3_pkg::REG_IMAGE_WIDTH:
                    begin
                        width_reg <= cfg.data[mf3_pkg::WIDTH_BITS-1:0];
                    end
                    mf3_pkg::REG_IMAGE_HEIGHT:
                    begin
                        height_reg <= cfg.data[mf3_pkg::HEIGHT_BITS-1:0];
                    end
                    default:
                    begin
                        // unused index, write dropped
                    end
                endcase
            end
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            credit_reg <= credit_next;
        end
    end

    // line ram, bypass and window registers
    mf3_window u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .acc_sample (acc_sample),
        .acc_col    (col_reg),
        .acc_ctrl   (acc_ctrl),
        .clearing   (clearing),
        .win_valid  (win_valid),
        .win_ctrl   (win_ctrl),
        .win_vals   (win_vals)
    );

    // three-stage median network
    mf3_median u_median (
        .clk           (clk),
        .rst_n         (rst_n),
        .win_valid     (win_valid),
        .win_ctrl      (win_ctrl),
        .win_vals      (win_vals),
        .res_valid     (res_valid),
        .res_median    (res_median),
        .res_frame_end (res_frame_end)
    );

    // result buffer toward med_out
    mf3_fifo u_fifo (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (res_valid),
        .push_median    (res_median),
        .push_frame_end (res_frame_end),
        .med_out        (med_out)
    );

`ifndef ASSERT_OFF
    a_credit_bound: assert property (
        @(posedge clk) disable iff (!rst_n)
        credit_reg <= mf3_pkg::FIFO_CNT_BITS'(mf3_pkg::FIFO_DEPTH)
    ) else $error("credit count above fifo depth");

    a_output_has_credit: assert property (
        @(posedge clk) disable iff (!rst_n) med_out.valid |-> (credit_reg != '0)
    ) else $error("result word shown without a reserved credit");

    a_no_accept_after_reset: assert property (
        @(posedge clk) disable iff (!rst_n) $rose(rst_n) |-> !pix_in.ready
    ) else $error("pixel word taken before line ram clearing");
`endif

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// self-checking testbench of the streaming 3x3 zero-padded median filter
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mf3_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 11;
    localparam int MAX_GAP       = 6;
    localparam int SETTLE_CYCLES = 16;      // pipeline drain before a register write
    localparam int TAIL_CYCLES   = 40;      // quiet time after the last expected word
    localparam int ITEM_TARGET   = 850;     // words sent by the extreme and random parts
    localparam int EXTREME_ITEMS = 48;      // upper bound on words sent at each extreme size
    localparam int CYCLE_LIMIT   = 600000;

    // index that names no register, the write must be ignored
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;

    localparam sample_t PIX_MAX  = 16'h7FFF;
    localparam sample_t PIX_MIN  = 16'h8000;
    localparam sample_t PIX_ZERO = 16'h0000;

    typedef enum logic {ROW_CONFIG, ROW_PIXEL} row_kind_t;
    typedef enum int {FRAME_CLEAN, FRAME_TRUNCATED, FRAME_OVERRUN, FRAME_PREFIX} frame_kind_t;

    // one row of the directed table; fixed rows carry the word read off by hand
    typedef struct {
        row_kind_t                 kind;
        logic [CFG_INDEX_BITS-1:0] target;
        logic [CFG_DATA_BITS-1:0]  value;
        sample_t                   pixel;
        bit                        fixed;
        bit                        fixed_has;
        sample_t                   fixed_median;
        bit                        fixed_end;
    } directed_row_t;

    typedef struct packed {
        sample_t median;
        logic    frame_end;
    } median_word_t;

    logic clk;
    logic rst_n;

    mf3_pix_if pix_ch ();
    mf3_med_if med_ch ();
    mf3_cfg_if cfg_ch ();

    median_filter_3x3_zero_pad uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pix_ch),
        .med_out (med_ch),
        .cfg     (cfg_ch)
    );

    // medians still owed by the block, oldest first
    median_word_t pending_medians [$];

    int error_count = 0;
    int cycle_count = 0;
    int items_sent  = 0;
    bit steady_mode = 1'b0;     // no random gaps on either side while set
    bit drained_once = 1'b0;

    // predictor copy of the block: sizes, line stores, window, stream position
    int      cfg_width  = RESET_WIDTH;
    int      cfg_height = RESET_HEIGHT;
    sample_t older_row [MAX_WIDTH];
    sample_t newer_row [MAX_WIDTH];
    sample_t win_px [WIN_SIZE];
    int      row_pos = 0;
    int      col_pos = 0;

    directed_row_t directed_rows [32];
    logic [CFG_DATA_BITS-1:0] extreme_sizes [4][2];

    always
    begin
        clk = 1'b1;
        #CLK_HALF;
        clk = 1'b0;
        #CLK_HALF;
    end

    // hard stop if the block hangs
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // width 0 acts as 1, anything above the line store acts as its size
    function automatic int active_width();
        if (cfg_width < 1)
            return 1;
        if (cfg_width > MAX_WIDTH)
            return MAX_WIDTH;
        return cfg_width;
    endfunction

    // height 0 acts as 1
    function automatic int active_height();
        return (cfg_height < 1) ? 1 : cfg_height;
    endfunction

    function automatic int draw_gap();
        return steady_mode ? 0 : int'($urandom_range(0, MAX_GAP));
    endfunction

    // one accepted word through the predictor: shift the window, update the
    // line stores and the position, and work out the median it releases
    task automatic predict_median(input sample_t smp, output bit has_word,
                                  output sample_t med, output bit last_px);
        int      w, h, r, c, cr, cc, slot, k, i, j, y, x;
        sample_t s, top, mid, key;
        sample_t vals [WIN_SIZE];
        begin
            w = active_width();
            h = active_height();
            r = row_pos;
            c = col_pos;

            // padding rows go into the stores as zero
            s = (r >= h) ? PIX_ZERO : smp;
            slot = (c < MAX_WIDTH) ? c : MAX_WIDTH - 1;
            top = older_row[slot];
            mid = newer_row[slot];
            older_row[slot] = mid;
            newer_row[slot] = s;

            for (k = 0; k < 3; k++)
            begin
                win_px[k * 3]     = win_px[k * 3 + 1];
                win_px[k * 3 + 1] = win_px[k * 3 + 2];
            end
            win_px[2] = top;
            win_px[5] = mid;
            win_px[8] = s;

            // center sits one row up and one column left, wrapping at column 0
            if (c == 0)
            begin
                cr = r - 2;
                cc = w - 1;
            end
            else
            begin
                cr = r - 1;
                cc = c - 1;
            end

            has_word = 1'b0;
            med = PIX_ZERO;
            last_px = 1'b0;
            if (cr >= 0 && cr < h && cc < w)
            begin
                for (k = 0; k < WIN_SIZE; k++)
                begin
                    y = cr - 1 + k / 3;
                    x = cc - 1 + k % 3;
                    vals[k] = (y < 0 || y >= h || x < 0 || x >= w) ? PIX_ZERO : win_px[k];
                end
                for (i = 1; i < WIN_SIZE; i++)
                begin
                    key = vals[i];
                    j = i;
                    while (j > 0 && vals[j - 1] > key)
                    begin
                        vals[j] = vals[j - 1];
                        j--;
                    end
                    vals[j] = key;
                end
                med = vals[4];
                last_px = (cr == h - 1 && cc == w - 1);
                has_word = 1'b1;
            end

            // the first word of the second padding row ends the frame, columns wrap at the width
            if (r >= h + 1)
            begin
                row_pos = 0;
                col_pos = 0;
            end
            else if (c + 1 >= w)
            begin
                col_pos = 0;
                row_pos = r + 1;
            end
            else
            begin
                col_pos = c + 1;
            end
        end
    endtask

    // drop pixel valid, wait for every owed median, then let the pipe settle
    task automatic hold_input(input int extra);
        pix_ch.valid <= 1'b0;
        while (pending_medians.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] target,
                                  input logic [CFG_DATA_BITS-1:0] value);
        hold_input(SETTLE_CYCLES);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= target;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (target == REG_IMAGE_WIDTH)
            cfg_width = int'(value[WIDTH_BITS-1:0]);
        else if (target == REG_IMAGE_HEIGHT)
            cfg_height = int'(value);
    endtask

    // one pixel word; valid stays high after the handshake so back-to-back
    // words need no second assignment in the same step
    task automatic send_pixel(input sample_t smp, input bit fixed, input bit fixed_has,
                              input sample_t fixed_median, input bit fixed_end);
        int           gap;
        bit           has_word;
        sample_t      med;
        bit           last_px;
        median_word_t word;
        begin
            gap = draw_gap();
            if (gap != 0)
            begin
                pix_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pix_ch.valid  <= 1'b1;
            pix_ch.sample <= smp;
            do
                @(posedge clk);
            while (!pix_ch.ready);

            predict_median(smp, has_word, med, last_px);
            if (fixed)
            begin
                has_word = fixed_has;
                med = fixed_median;
                last_px = fixed_end;
            end
            if (has_word)
            begin
                word.median = med;
                word.frame_end = last_px;
                pending_medians.push_back(word);
            end
        end
    endtask

    // a frame at the current sizes with its padding; broken ones stop short
    // or run into the next frame, a prefix sends only the first few words
    task automatic run_frame(input frame_kind_t kind);
        int      total, frame_len, i;
        sample_t smp;
        begin
            total = active_width() * active_height() + active_width() + 1;
            case (kind)
                FRAME_TRUNCATED: frame_len = $urandom_range(1, total - 1);
                FRAME_OVERRUN:   frame_len = total + $urandom_range(1, active_width() + 2);
                FRAME_PREFIX:    frame_len = (total < EXTREME_ITEMS) ? total : EXTREME_ITEMS;
                default:         frame_len = total;
            endcase
            for (i = 0; i < frame_len; i++)
            begin
                // sender holds off until the result side is empty
                if ($urandom_range(0, 199) == 0 || (!drained_once && i == frame_len / 2))
                begin
                    hold_input(1);
                    drained_once = 1'b1;
                end
                case ($urandom_range(0, 15))
                    0:       smp = PIX_MAX;
                    1:       smp = PIX_MIN;
                    2:       smp = PIX_ZERO;
                    default: smp = sample_t'($urandom_range(0, 16'hFFFF));
                endcase
                send_pixel(smp, 1'b0, 1'b0, PIX_ZERO, 1'b0);
                items_sent++;
            end
        end
    endtask

    // result side: random stalls, every accepted word checked in order
    initial
    begin : median_checker
        int           stall;
        median_word_t expected;
        med_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = draw_gap();
            if (stall != 0)
            begin
                med_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            med_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!med_ch.valid);

            if (pending_medians.size() == 0)
            begin
                $error("unexpected word: median %0d frame_end %0b",
                       med_ch.median, med_ch.frame_end);
                error_count++;
            end
            else
            begin
                expected = pending_medians.pop_front();
                if (med_ch.median !== expected.median)
                begin
                    $error("median: expected %0d, actual %0d", expected.median, med_ch.median);
                    error_count++;
                end
                if (med_ch.frame_end !== expected.frame_end)
                begin
                    $error("frame_end: expected %0b, actual %0b",
                           expected.frame_end, med_ch.frame_end);
                    error_count++;
                end
            end
        end
    end

    initial
    begin : stimulus
        int          p, f, nframes, pick;
        logic [CFG_DATA_BITS-1:0] width_val, height_val;
        frame_kind_t kind;

        rst_n = 1'b0;
        pix_ch.valid  <= 1'b0;
        pix_ch.sample <= PIX_ZERO;
        cfg_ch.valid  <= 1'b0;
        cfg_ch.index  <= REG_IMAGE_WIDTH;
        cfg_ch.data   <= '0;
        foreach (older_row[i])
        begin
            older_row[i] = PIX_ZERO;
            newer_row[i] = PIX_ZERO;
        end
        foreach (win_px[i])
            win_px[i] = PIX_ZERO;

        // directed part: 1x1 frames at both ends of the sample range, width
        // and height zero, a 3x3 frame whose edges and corners are easy to
        // read, and a short 1x2 frame left to the predictor
        directed_rows = '{
            '{ROW_CONFIG, REG_UNUSED,       12'hFFF, PIX_ZERO, 1'b0, 1'b0, PIX_ZERO, 1'b0},
            '{ROW_CONFIG, REG_IMAGE_WIDTH,  12'd1,   PIX_ZERO, 1'b0, 1'b0, PIX_ZERO, 1'b0},
            '{ROW_CONFIG, REG_IMAGE_HEIGHT, 12'd1,   PIX_ZERO, 1'b0, 1'b0, PIX_ZERO, 1'b0},
            '{ROW_PIXEL,  REG_UNUSED,       12'd0,   PIX_MAX,  1'b1, 1'b0, PIX_ZERO, 1'b0},
            '{ROW_PIXEL,  REG_UNUSED,       12'd0,   PIX_MIN,  1'b1, 1'b0, PIX_ZERO, 1'b0},
            '{ROW_PIXEL,  REG_UNUSED,       12'd0,   PIX_MAX,  1'b1, 1'b1, PIX_ZERO, 1'b1},
            '{ROW_CONFIG, REG_IMAGE_WIDTH,  12'd0,   PIX_ZERO, 1'b0, 1'b0, PIX_ZERO, 1'b0},
            '{ROW_CONFIG, REG_IMAGE_HEIGHT, 12'd0,   PIX_ZERO, 1'b0, 1'b0, PIX_ZERO, 1'b0},
            '{ROW_PIXEL,  REG_UNUSED,       12'd0,   PIX_MIN,  1'b1, 1'b0, PIX_ZERO, 1'b0},
            '{ROW_PIXEL,  REG_UNUSED,       12'd0,   PIX_MAX,  1'b1, 1'b0, PIX_ZERO, 1'b0},
            '{ROW_PIXEL,  REG_UNUSED,       12'd0,   PIX_MIN,  1'b1, 1'b1, PIX_ZERO, 1'b1},
            '{ROW_CONFIG, REG_IMAGE_WIDTH,  12'd3,   PIX_ZERO, 1'b0, 1'b0, PIX_ZERO, 1'b0},
            '{ROW_CONFIG, REG_IMAGE_HEIGHT, 12'd3,   PIX_ZERO, 1'b0, 1'b0, PIX_ZERO, 1'b0},
            '{ROW_PIXEL,  REG_UNUSED,       12'd0,   PIX_MAX,  1'b1, 1'b0, PIX_ZERO, 1'b0},
            '{ROW_PIXEL,  REG_UNUSED,       12'd0,   PIX_MAX,  1'b1, 1'b0, PIX_ZERO, 1'b0},
            '{ROW_PIXEL,  REG_UNUSED,       12'd0,   PIX_MAX,  1'b1, 1'b0, PIX_ZERO, 1'b0},
            '{ROW_PIXEL,  REG_UNUSED,       12'd0,   PIX_MAX,  1'b1, 1'b0, PIX_ZERO, 1'b0},
            '{ROW_PIXEL,  REG_UNUSED,       12'd0,   PIX_MAX,  1'b1, 1'b1, PIX_ZERO, 1'b0},
            '{ROW_PIXEL,  REG_UNUSED,       12'd0,   PIX_MAX,  1'b1, 1'b1, PIX_MAX,  1'b0},
            '{ROW_PIXEL,  REG_UNUSED,       12'd0,   PIX_MAX,  1'b1, 1'b1, PIX_ZERO, 1'b0},
            '{ROW_PIXEL,  REG_UNUSED,       12'd0,   PIX_MAX,  1'b1, 1'b1, PIX_MAX,  1'b0},
            '{ROW_PIXEL,  REG_UNUSED,       12'd0,   PIX_MAX,  1'b1, 1'b1, PIX_MAX,  1'b0},
            '{ROW_PIXEL,  REG_UNUSED,       12'd0,   PIX_MIN,  1'b1, 1'b1, PIX_MAX,  1'b0},
            '{ROW_PIXEL,  REG_UNUSED,       12'd0,   PIX_MIN,  1'b1, 1'b1, PIX_ZERO, 1'b0},
            '{ROW_PIXEL,  REG_UNUSED,       12'd0,   PIX_MIN,  1'b1, 1'b1, PIX_MAX,  1'b0},
            '{ROW_PIXEL,  REG_UNUSED,       12'd0,   PIX_MIN,  1'b1, 1'b1, PIX_ZERO, 1'b1},
            '{ROW_CONFIG, REG_IMAGE_WIDTH,  12'd1,   PIX_ZERO, 1'b0, 1'b0, PIX_ZERO, 1'b0},
            '{ROW_CONFIG, REG_IMAGE_HEIGHT, 12'd2,   PIX_ZERO, 1'b0, 1'b0, PIX_ZERO, 1'b0},
            '{ROW_PIXEL,  REG_UNUSED,       12'd0,   16'sd1,   1'b0, 1'b0, PIX_ZERO, 1'b0},
            '{ROW_PIXEL,  REG_UNUSED,       12'd0,   -16'sd2,  1'b0, 1'b0, PIX_ZERO, 1'b0},
            '{ROW_PIXEL,  REG_UNUSED,       12'd0,   16'sd300, 1'b0, 1'b0, PIX_ZERO, 1'b0},
            '{ROW_PIXEL,  REG_UNUSED,       12'd0,   -16'sd32767, 1'b0, 1'b0, PIX_ZERO, 1'b0}
        };

        // size extremes: full line store, width past it with the top data
        // bit set, the tallest frame, width zero; the first three get a short
        // stretch of words, so the next size change lands inside a frame
        extreme_sizes = '{
            '{12'd1024, 12'd1},
            '{12'hFFF,  12'd0},
            '{12'd1,    12'hFFF},
            '{12'd0,    12'd2}
        };

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // the block clears its line ram first; the first pixel handshake waits it out
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CONFIG)
                write_register(directed_rows[i].target, directed_rows[i].value);
            else
                send_pixel(directed_rows[i].pixel, directed_rows[i].fixed,
                           directed_rows[i].fixed_has, directed_rows[i].fixed_median,
                           directed_rows[i].fixed_end);
        end

        for (p = 0; p < 4; p++)
        begin
            write_register(REG_IMAGE_WIDTH, extreme_sizes[p][0]);
            write_register(REG_IMAGE_HEIGHT, extreme_sizes[p][1]);
            steady_mode = (p % 2 == 0);
            run_frame(FRAME_PREFIX);
        end

        // random phases on small images; broken frames leave the position
        // mid-frame so the next size change lands inside a frame
        while (items_sent < ITEM_TARGET)
        begin
            case ($urandom_range(0, 9))
                0:       width_val = 12'($urandom_range(0, 1));
                1:       width_val = 12'($urandom_range(13, 40));
                default: width_val = 12'($urandom_range(2, 8));
            endcase
            height_val = ($urandom_range(0, 9) == 0) ? 12'd0 : 12'($urandom_range(1, 6));
            if ($urandom_range(0, 7) == 0)
                write_register(REG_UNUSED, 12'($urandom_range(0, 12'hFFF)));
            write_register(REG_IMAGE_WIDTH, width_val);
            write_register(REG_IMAGE_HEIGHT, height_val);
            steady_mode = ($urandom_range(0, 3) == 0);
            nframes = $urandom_range(1, 3);
            for (f = 0; f < nframes && items_sent < ITEM_TARGET; f++)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 7)
                    kind = FRAME_CLEAN;
                else if (pick < 9)
                    kind = FRAME_TRUNCATED;
                else
                    kind = FRAME_OVERRUN;
                run_frame(kind);
            end
        end

        // all words in, wait for the last medians and a quiet tail
        steady_mode = 1'b0;
        hold_input(TAIL_CYCLES);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/mf3_pkg.sv
hw/rtl/mf3_ifs.sv
hw/rtl/mf3_ram.sv
hw/rtl/mf3_window.sv
hw/rtl/mf3_median.sv
hw/rtl/mf3_fifo.sv
hw/rtl/median_filter_3x3_zero_pad.sv
sim/testbench.sv
